### sv/resistor_ladder_keypad_events_assert.svh
// ----------------------------------------------------------------------------
// Keypad event block assertion macros
// Concurrent assertion helpers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RESISTOR_LADDER_KEYPAD_EVENTS_ASSERT_SVH
`define RESISTOR_LADDER_KEYPAD_EVENTS_ASSERT_SVH

`ifndef SYNTH
`define RLKE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("keypad assertion failed");
`define RLKE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keypad assertion failed");
`else
`define RLKE_ASSERT(lbl, prop)
`define RLKE_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

### sv/rlke_pkg.sv
// ----------------------------------------------------------------------------
// rlke_pkg
// Shared constants, codes and types of the resistor-ladder keypad block.
// ----------------------------------------------------------------------------
package rlke_pkg;

	localparam int SAMPLE_BITS   = 12;
	localparam int KEY_COUNT     = 5;
	localparam int DEBOUNCE_LEN  = 4;
	localparam int LIMIT_BITS    = 12;
	localparam int LIMITS_BITS   = 60;
	localparam int KEY_IDX_BITS  = 3;
	localparam int CODE_BITS     = 3;
	localparam int EVENT_CODES   = 6;
	localparam int CNT_BITS      = 8;
	localparam int HOLD_BITS     = 9;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = 2;
	localparam int CFG_ADDR_BITS = 6;
	localparam int CFG_DATA_BITS = 64;

	localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;
	localparam logic [SAMPLE_BITS-1:0] NOKEY_MAX  = FULL_SCALE - (FULL_SCALE >> 5);
	localparam logic [CNT_BITS-1:0]    REPEAT_SAT = 8'd255;

	localparam logic [CNT_BITS-1:0]  RST_SLOW_REPEAT = 8'd10;
	localparam logic [CNT_BITS-1:0]  RST_SLOW_SKIP   = 8'd10;
	localparam logic [CNT_BITS-1:0]  RST_FAST_SKIP   = 8'd2;
	localparam logic [HOLD_BITS-1:0] RST_HOLD_COUNT  = 9'd256;

	typedef enum logic [CODE_BITS-1:0] {
		EV_PRESS   = 3'd0,
		EV_REPEAT  = 3'd1,
		EV_HELD1   = 3'd2,
		EV_HELD2   = 3'd3,
		EV_HELD3   = 3'd4,
		EV_RELEASE = 3'd5
	} ev_code_t;

	typedef enum logic [2:0] {
		REG_KEY_LOW   = 3'd0,
		REG_KEY_HIGH  = 3'd1,
		REG_SLOW_RPT  = 3'd2,
		REG_SLOW_SKIP = 3'd3,
		REG_FAST_SKIP = 3'd4,
		REG_HOLD1     = 3'd5,
		REG_HOLD2     = 3'd6,
		REG_HOLD3     = 3'd7
	} reg_idx_t;

	// one bit per key and event code; ascending bit order is emission order
	typedef logic [KEY_COUNT-1:0][EVENT_CODES-1:0] ev_mask_t;

	typedef struct packed {
		logic [LIMITS_BITS-1:0] key_low_limits;
		logic [LIMITS_BITS-1:0] key_high_limits;
		logic [CNT_BITS-1:0]    slow_repeat_count;
		logic [CNT_BITS-1:0]    slow_skip;
		logic [CNT_BITS-1:0]    fast_skip;
		logic [HOLD_BITS-1:0]   hold_count_one;
		logic [HOLD_BITS-1:0]   hold_count_two;
		logic [HOLD_BITS-1:0]   hold_count_three;
	} cfg_t;

endpackage

### sv/resistor_ladder_keypad_events.sv
// ----------------------------------------------------------------------------
// resistor_ladder_keypad_events
// Resistor-ladder keypad decoder with debounce, auto-repeat and held events.
// ----------------------------------------------------------------------------
// Input channel: one converter sample per request (in_valid, in_stall,
// adc_sample). Output channel: one key event per request (out_valid,
// out_stall, key_index, event_code, last); last marks the final event of a
// sample, and a sample that causes no event produces no request at all.
// Setup goes through the APB port, 64-bit registers at byte address 8*i, to be
// written only while the block is idle; the block leaves that rule to the user.
// The first event of a sample goes through the event queue and the output
// register before it is presented. Throughput: a sample every cycle on the
// input side while the 4-entry event queue has room; the output side delivers
// one event per cycle while out_stall is low, a sample's events in turn.
// Reset clears all key state, loads the register defaults and empties the
// queue. While out_stall is high the presented event holds, the queue fills,
// and in_stall rises once it is full.
// ----------------------------------------------------------------------------
module resistor_ladder_keypad_events (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [rlke_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [rlke_pkg::CFG_DATA_BITS-1:0] pwdata,
	output logic [rlke_pkg::CFG_DATA_BITS-1:0] prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [rlke_pkg::SAMPLE_BITS-1:0]   adc_sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [rlke_pkg::KEY_IDX_BITS-1:0]  key_index,
	output logic [rlke_pkg::CODE_BITS-1:0]     event_code,
	output logic                               last
);

	rlke_pkg::cfg_t     cfg_q;
	rlke_pkg::reg_idx_t reg_idx;
	rlke_pkg::ev_mask_t fr_mask;
	rlke_pkg::ev_mask_t q_head;
	logic               wr_en;
	logic               take;
	logic               fr_push;
	logic               q_full;
	logic               q_empty;
	logic               q_pop;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = rlke_pkg::reg_idx_t'(paddr[rlke_pkg::CFG_ADDR_BITS-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_low_limits    <= '0;
			cfg_q.key_high_limits   <= '0;
			cfg_q.slow_repeat_count <= rlke_pkg::RST_SLOW_REPEAT;
			cfg_q.slow_skip         <= rlke_pkg::RST_SLOW_SKIP;
			cfg_q.fast_skip         <= rlke_pkg::RST_FAST_SKIP;
			cfg_q.hold_count_one    <= rlke_pkg::RST_HOLD_COUNT;
			cfg_q.hold_count_two    <= rlke_pkg::RST_HOLD_COUNT;
			cfg_q.hold_count_three  <= rlke_pkg::RST_HOLD_COUNT;
		end else if (wr_en) begin
			case (reg_idx)
				rlke_pkg::REG_KEY_LOW: begin
					cfg_q.key_low_limits <= pwdata[rlke_pkg::LIMITS_BITS-1:0];
				end
				rlke_pkg::REG_KEY_HIGH: begin
					cfg_q.key_high_limits <= pwdata[rlke_pkg::LIMITS_BITS-1:0];
				end
				rlke_pkg::REG_SLOW_RPT: begin
					cfg_q.slow_repeat_count <= pwdata[rlke_pkg::CNT_BITS-1:0];
				end
				rlke_pkg::REG_SLOW_SKIP: begin
					cfg_q.slow_skip <= pwdata[rlke_pkg::CNT_BITS-1:0];
				end
				rlke_pkg::REG_FAST_SKIP: begin
					cfg_q.fast_skip <= pwdata[rlke_pkg::CNT_BITS-1:0];
				end
				rlke_pkg::REG_HOLD1: begin
					cfg_q.hold_count_one <= pwdata[rlke_pkg::HOLD_BITS-1:0];
				end
				rlke_pkg::REG_HOLD2: begin
					cfg_q.hold_count_two <= pwdata[rlke_pkg::HOLD_BITS-1:0];
				end
				rlke_pkg::REG_HOLD3: begin
					cfg_q.hold_count_three <= pwdata[rlke_pkg::HOLD_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rlke_pkg::REG_KEY_LOW:   prdata = rlke_pkg::CFG_DATA_BITS'(cfg_q.key_low_limits);
			rlke_pkg::REG_KEY_HIGH:  prdata = rlke_pkg::CFG_DATA_BITS'(cfg_q.key_high_limits);
			rlke_pkg::REG_SLOW_RPT:  prdata = rlke_pkg::CFG_DATA_BITS'(cfg_q.slow_repeat_count);
			rlke_pkg::REG_SLOW_SKIP: prdata = rlke_pkg::CFG_DATA_BITS'(cfg_q.slow_skip);
			rlke_pkg::REG_FAST_SKIP: prdata = rlke_pkg::CFG_DATA_BITS'(cfg_q.fast_skip);
			rlke_pkg::REG_HOLD1:     prdata = rlke_pkg::CFG_DATA_BITS'(cfg_q.hold_count_one);
			rlke_pkg::REG_HOLD2:     prdata = rlke_pkg::CFG_DATA_BITS'(cfg_q.hold_count_two);
			rlke_pkg::REG_HOLD3:     prdata = rlke_pkg::CFG_DATA_BITS'(cfg_q.hold_count_three);
			default:                 prdata = '0;
		endcase
	end

	assign in_stall = q_full;
	assign take     = in_valid && !q_full;

	rlke_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.take   (take),
		.sample (adc_sample),
		.push   (fr_push),
		.mask   (fr_mask)
	);

	rlke_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_push),
		.wdata  (fr_mask),
		.pop    (q_pop),
		.rdata  (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	rlke_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.empty      (q_empty),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.key_index  (key_index),
		.event_code (event_code),
		.last       (last)
	);

endmodule

### sv/rlke_front.sv
// ----------------------------------------------------------------------------
// rlke_front
// Classifies each sample, updates per-key debounce and repeat state and
// builds the mask of events the sample causes.
// ----------------------------------------------------------------------------
`include "resistor_ladder_keypad_events_assert.svh"

module rlke_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rlke_pkg::cfg_t                   cfg,
	input  logic                             take,
	input  logic [rlke_pkg::SAMPLE_BITS-1:0] sample,
	output logic                             push,
	output rlke_pkg::ev_mask_t               mask
);

	logic [rlke_pkg::DEBOUNCE_LEN-1:0] hist_q [rlke_pkg::KEY_COUNT];
	logic [rlke_pkg::DEBOUNCE_LEN-1:0] hist_d [rlke_pkg::KEY_COUNT];
	logic [rlke_pkg::DEBOUNCE_LEN:0]   hist_ext [rlke_pkg::KEY_COUNT];
	logic [rlke_pkg::CNT_BITS-1:0]     skip_q [rlke_pkg::KEY_COUNT];
	logic [rlke_pkg::CNT_BITS-1:0]     skip_d [rlke_pkg::KEY_COUNT];
	logic [rlke_pkg::CNT_BITS-1:0]     skip_inc [rlke_pkg::KEY_COUNT];
	logic [rlke_pkg::CNT_BITS-1:0]     lim [rlke_pkg::KEY_COUNT];
	logic [rlke_pkg::CNT_BITS-1:0]     rep_q [rlke_pkg::KEY_COUNT];
	logic [rlke_pkg::CNT_BITS-1:0]     rep_d [rlke_pkg::KEY_COUNT];
	logic [rlke_pkg::HOLD_BITS-1:0]    rep_ext [rlke_pkg::KEY_COUNT];
	logic [rlke_pkg::KEY_COUNT-1:0]    held_q;
	logic [rlke_pkg::KEY_COUNT-1:0]    held_d;
	logic [rlke_pkg::KEY_COUNT-1:0]    in_win;
	logic [rlke_pkg::KEY_COUNT-1:0]    key_bit;
	logic [rlke_pkg::KEY_COUNT-1:0]    act;
	logic [rlke_pkg::KEY_IDX_BITS-1:0] recog;
	logic                              have_key;

	always_comb begin
		have_key = 1'b0;
		recog    = '0;
		for (int k = 0; k < rlke_pkg::KEY_COUNT; k++) begin
			in_win[k] = (sample >= cfg.key_low_limits[k*rlke_pkg::LIMIT_BITS +: rlke_pkg::LIMIT_BITS])
				&& (sample < cfg.key_high_limits[k*rlke_pkg::LIMIT_BITS +: rlke_pkg::LIMIT_BITS]);
			if (sample <= rlke_pkg::NOKEY_MAX && in_win[k]) begin
				have_key = 1'b1;
				recog    = rlke_pkg::KEY_IDX_BITS'(k);
			end
		end
		for (int k = 0; k < rlke_pkg::KEY_COUNT; k++) begin
			key_bit[k] = have_key && (recog == rlke_pkg::KEY_IDX_BITS'(k));
		end
	end

	always_comb begin
		mask = '0;
		for (int k = 0; k < rlke_pkg::KEY_COUNT; k++) begin
			hist_ext[k] = {hist_q[k], key_bit[k]};
			hist_d[k]   = hist_ext[k][rlke_pkg::DEBOUNCE_LEN-1:0];
			act[k]      = &hist_d[k];
			held_d[k]   = held_q[k];
			skip_d[k]   = skip_q[k];
			rep_d[k]    = rep_q[k];
			rep_ext[k]  = {1'b0, rep_q[k]};
			skip_inc[k] = skip_q[k] + 8'd1;
			lim[k]      = (rep_q[k] < cfg.slow_repeat_count) ? cfg.slow_skip : cfg.fast_skip;
			if (act[k]) begin
				if (!held_q[k]) begin
					held_d[k] = 1'b1;
					skip_d[k] = '0;
					rep_d[k]  = '0;
					mask[k][rlke_pkg::EV_PRESS] = 1'b1;
				end else if (skip_inc[k] > lim[k]) begin
					mask[k][rlke_pkg::EV_REPEAT] = 1'b1;
					mask[k][rlke_pkg::EV_HELD1]  = (cfg.hold_count_one == rep_ext[k]);
					mask[k][rlke_pkg::EV_HELD2]  = (cfg.hold_count_two == rep_ext[k]);
					mask[k][rlke_pkg::EV_HELD3]  = (cfg.hold_count_three == rep_ext[k]);
					skip_d[k] = '0;
					if (rep_q[k] != rlke_pkg::REPEAT_SAT) begin
						rep_d[k] = rep_q[k] + 8'd1;
					end
				end else begin
					skip_d[k] = skip_inc[k];
				end
			end else if (hist_d[k] == '0 && held_q[k]) begin
				held_d[k] = 1'b0;
				mask[k][rlke_pkg::EV_RELEASE] = 1'b1;
			end
		end
	end

	assign push = take && (|mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			for (int k = 0; k < rlke_pkg::KEY_COUNT; k++) begin
				hist_q[k] <= '0;
				skip_q[k] <= '0;
				rep_q[k]  <= '0;
			end
		end else if (take) begin
			held_q <= held_d;
			for (int k = 0; k < rlke_pkg::KEY_COUNT; k++) begin
				hist_q[k] <= hist_d[k];
				skip_q[k] <= skip_d[k];
				rep_q[k]  <= rep_d[k];
			end
		end
	end

	// only the recognized key can reach a full history
	`RLKE_ASSERT(a_one_active, $onehot0(act))
	`RLKE_ASSERT_IMP(a_press_only_unheld, take && (|act) && !(|(act & held_q)), |mask)

endmodule

### sv/rlke_fifo.sv
// ----------------------------------------------------------------------------
// rlke_fifo
// Short queue of event masks between the classifier and the serializer.
// ----------------------------------------------------------------------------
`include "resistor_ladder_keypad_events_assert.svh"

module rlke_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rlke_pkg::ev_mask_t wdata,
	input  logic               pop,
	output rlke_pkg::ev_mask_t rdata,
	output logic               full,
	output logic               empty
);

	rlke_pkg::ev_mask_t                 mem_q [rlke_pkg::FIFO_DEPTH];
	logic [rlke_pkg::FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [rlke_pkg::FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [rlke_pkg::FIFO_PTR_BITS:0]   count_q;

	assign full  = (count_q == (rlke_pkg::FIFO_PTR_BITS+1)'(rlke_pkg::FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`RLKE_ASSERT_IMP(a_no_overflow, push, !full)
	`RLKE_ASSERT_IMP(a_no_underflow, pop, !empty)

endmodule

### sv/rlke_back.sv
// ----------------------------------------------------------------------------
// rlke_back
// Serializes event masks into one event per cycle while out_stall is low, in key and code order.
// ----------------------------------------------------------------------------
`include "resistor_ladder_keypad_events_assert.svh"

module rlke_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rlke_pkg::ev_mask_t                head,
	input  logic                              empty,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rlke_pkg::KEY_IDX_BITS-1:0] key_index,
	output logic [rlke_pkg::CODE_BITS-1:0]    event_code,
	output logic                              last
);

	rlke_pkg::ev_mask_t                work_q;
	rlke_pkg::ev_mask_t                src;
	rlke_pkg::ev_mask_t                rem;
	logic [rlke_pkg::KEY_IDX_BITS-1:0] sel_k;
	logic [rlke_pkg::CODE_BITS-1:0]    sel_c;
	logic                              load;
	logic                              have;
	logic                              work_busy;
	logic                              out_valid_q;
	logic [rlke_pkg::KEY_IDX_BITS-1:0] key_q;
	logic [rlke_pkg::CODE_BITS-1:0]    code_q;
	logic                              last_q;

	assign load      = !out_valid_q || !out_stall;
	assign work_busy = |work_q;
	assign src       = work_busy ? work_q : (empty ? '0 : head);
	assign have      = |src;
	assign pop       = load && !work_busy && !empty;

	always_comb begin
		sel_k = '0;
		sel_c = '0;
		for (int k = rlke_pkg::KEY_COUNT - 1; k >= 0; k--) begin
			if (|src[k]) begin
				sel_k = rlke_pkg::KEY_IDX_BITS'(k);
			end
		end
		for (int c = rlke_pkg::EVENT_CODES - 1; c >= 0; c--) begin
			if (src[sel_k][c]) begin
				sel_c = rlke_pkg::CODE_BITS'(c);
			end
		end
		rem = src;
		rem[sel_k][sel_c] = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			work_q      <= '0;
		end else if (load) begin
			out_valid_q <= have;
			work_q      <= rem;
		end
	end

	always_ff @(posedge clk) begin
		if (load && have) begin
			key_q  <= sel_k;
			code_q <= sel_c;
			last_q <= ~|rem;
		end
	end

	assign out_valid  = out_valid_q;
	assign key_index  = key_q;
	assign event_code = code_q;
	assign last       = last_q;

	`RLKE_ASSERT_IMP(a_no_pop_while_busy, work_busy, !pop)

endmodule

### tb/tb_resistor_ladder_keypad_events.sv
// ----------------------------------------------------------------------------
// tb_resistor_ladder_keypad_events
// Self-checking bench for the ladder keypad event block. Samples go in through
// a queue-fed driver with random gaps; a local keypad decoder predicts the
// press/repeat/held/release stream, and the monitor checks every event against
// it. Registers are reprogrammed over APB between phases while the block idles.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_resistor_ladder_keypad_events;

	import rlke_pkg::*;

	localparam int MAX_EVENTS     = 8;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int RANDOM_PHASES  = 5;
	localparam int PHASE_SAMPLES  = 22;

	localparam logic [LIMITS_BITS-1:0] LADDER_LOW  =
		{12'd2600, 12'd1800, 12'd1000, 12'd400, 12'd0};
	localparam logic [LIMITS_BITS-1:0] LADDER_HIGH =
		{12'd4095, 12'd2600, 12'd1800, 12'd1000, 12'd500};

	typedef struct packed {
		logic [KEY_IDX_BITS-1:0] key_idx;
		ev_code_t                code;
		logic                    last;
	} key_event_t;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     psel       = 1'b0;
	logic                     penable    = 1'b0;
	logic                     pwrite     = 1'b0;
	logic [CFG_ADDR_BITS-1:0] paddr      = '0;
	logic [CFG_DATA_BITS-1:0] pwdata     = '0;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic                     pready;
	logic                     in_valid   = 1'b0;
	logic                     in_stall;
	logic [SAMPLE_BITS-1:0]   adc_sample = '0;
	logic                     out_valid;
	logic                     out_stall  = 1'b0;
	logic [KEY_IDX_BITS-1:0]  key_index;
	logic [CODE_BITS-1:0]     event_code;
	logic                     last;

	// register shadow
	logic [LIMITS_BITS-1:0] lim_low       = '0;
	logic [LIMITS_BITS-1:0] lim_high      = '0;
	logic [CNT_BITS-1:0]    slow_rpt_cfg  = RST_SLOW_REPEAT;
	logic [CNT_BITS-1:0]    slow_skip_cfg = RST_SLOW_SKIP;
	logic [CNT_BITS-1:0]    fast_skip_cfg = RST_FAST_SKIP;
	logic [HOLD_BITS-1:0]   hold_cfg [3]  = '{RST_HOLD_COUNT, RST_HOLD_COUNT, RST_HOLD_COUNT};

	// per-key decoder state
	logic [DEBOUNCE_LEN-1:0] key_hist [KEY_COUNT] = '{default: '0};
	logic                    key_down [KEY_COUNT] = '{default: 1'b0};
	logic [CNT_BITS-1:0]     skip_cnt [KEY_COUNT] = '{default: '0};
	logic [CNT_BITS-1:0]     rpt_cnt  [KEY_COUNT] = '{default: '0};

	key_event_t burst_buf [MAX_EVENTS];
	int         burst_len;

	logic [SAMPLE_BITS-1:0] sample_queue [$];
	key_event_t             pending_events [$];

	int   mismatch_count = 0;
	int   idle_cycles    = 0;
	int   send_gap       = 0;
	int   recv_wait      = 0;
	bit   send_calm      = 1'b0;
	bit   recv_calm      = 1'b0;
	logic in_taken       = 1'b0;
	logic out_taken      = 1'b0;

	resistor_ladder_keypad_events u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.adc_sample (adc_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.key_index  (key_index),
		.event_code (event_code),
		.last       (last)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 15) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 6);
	endfunction

	task automatic add_event(input int key, input ev_code_t code);
		if (burst_len < MAX_EVENTS) begin
			burst_buf[burst_len] = '{key_idx: key[KEY_IDX_BITS-1:0], code: code, last: 1'b0};
			burst_len++;
		end
	endtask

	task automatic decode_sample(input logic [SAMPLE_BITS-1:0] s);
		int                  win;
		logic [CNT_BITS-1:0] thr;
		win = -1;
		burst_len = 0;
		if (s <= NOKEY_MAX) begin
			for (int k = 0; k < KEY_COUNT; k++) begin
				if (s >= lim_low[k*LIMIT_BITS +: LIMIT_BITS] &&
					s < lim_high[k*LIMIT_BITS +: LIMIT_BITS])
					win = k;
			end
		end
		for (int k = 0; k < KEY_COUNT; k++) begin
			key_hist[k] = {key_hist[k][DEBOUNCE_LEN-2:0], win == k};
			if (&key_hist[k]) begin
				if (!key_down[k]) begin
					key_down[k] = 1'b1;
					skip_cnt[k] = '0;
					rpt_cnt[k]  = '0;
					add_event(k, EV_PRESS);
				end else begin
					thr = (rpt_cnt[k] < slow_rpt_cfg) ? slow_skip_cfg : fast_skip_cfg;
					skip_cnt[k] = skip_cnt[k] + 1'b1;
					if (skip_cnt[k] > thr) begin
						add_event(k, EV_REPEAT);
						for (int h = 0; h < 3; h++) begin
							if (hold_cfg[h] == {1'b0, rpt_cnt[k]})
								add_event(k, ev_code_t'(EV_HELD1 + h));
						end
						skip_cnt[k] = '0;
						if (rpt_cnt[k] != REPEAT_SAT)
							rpt_cnt[k] = rpt_cnt[k] + 1'b1;
					end
				end
			end else if (key_hist[k] == '0 && key_down[k]) begin
				key_down[k] = 1'b0;
				add_event(k, EV_RELEASE);
			end
		end
		for (int i = 0; i < burst_len; i++) begin
			burst_buf[i].last = (i == burst_len - 1);
			pending_events.push_back(burst_buf[i]);
		end
	endtask

	task automatic check_event();
		key_event_t want;
		if (pending_events.size() == 0) begin
			$display("%0t: unexpected event: expected none, got key %0d code %0d last %0b",
				$time, key_index, event_code, last);
			mismatch_count++;
		end else begin
			want = pending_events.pop_front();
			if (key_index !== want.key_idx) begin
				$display("%0t: key_index expected %0d got %0d", $time, want.key_idx, key_index);
				mismatch_count++;
			end
			if (event_code !== want.code) begin
				$display("%0t: event_code expected %0d got %0d", $time, want.code, event_code);
				mismatch_count++;
			end
			if (last !== want.last) begin
				$display("%0t: last expected %0b got %0b", $time, want.last, last);
				mismatch_count++;
			end
		end
	endtask

	// predict on accepted requests, check accepted events
	always @(posedge clk) begin
		in_taken  <= in_valid && !in_stall;
		out_taken <= out_valid && !out_stall;
		if (arst_n) begin
			if (in_valid && !in_stall)
				decode_sample(adc_sample);
			if (out_valid && !out_stall)
				check_event();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(psel && penable && pwrite && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// sample driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (sample_queue.size() > 0) begin
				adc_sample <= sample_queue.pop_front();
				in_valid   <= 1'b1;
				send_gap = draw_wait(send_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// event receiver backpressure
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_taken)
				recv_wait = draw_wait(recv_calm);
			if (recv_wait > 0) begin
				recv_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_KEY_LOW:   lim_low       = val[LIMITS_BITS-1:0];
			REG_KEY_HIGH:  lim_high      = val[LIMITS_BITS-1:0];
			REG_SLOW_RPT:  slow_rpt_cfg  = val[CNT_BITS-1:0];
			REG_SLOW_SKIP: slow_skip_cfg = val[CNT_BITS-1:0];
			REG_FAST_SKIP: fast_skip_cfg = val[CNT_BITS-1:0];
			REG_HOLD1:     hold_cfg[0]   = val[HOLD_BITS-1:0];
			REG_HOLD2:     hold_cfg[1]   = val[HOLD_BITS-1:0];
			REG_HOLD3:     hold_cfg[2]   = val[HOLD_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic program_all(input logic [CFG_DATA_BITS-1:0] lo, hi, srpt, sskip, fskip,
		h1, h2, h3);
		write_reg(REG_KEY_LOW, lo);
		write_reg(REG_KEY_HIGH, hi);
		write_reg(REG_SLOW_RPT, srpt);
		write_reg(REG_SLOW_SKIP, sskip);
		write_reg(REG_FAST_SKIP, fskip);
		write_reg(REG_HOLD1, h1);
		write_reg(REG_HOLD2, h2);
		write_reg(REG_HOLD3, h3);
	endtask

	// wait for the block to drain before touching registers or ending
	task automatic settle();
		while (sample_queue.size() != 0 || in_valid || pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int hold_pick();
		return ($urandom_range(0, 3) == 0) ? int'(RST_HOLD_COUNT) : $urandom_range(0, 6);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] window_sample(input int k);
		int lo;
		int hi;
		lo = lim_low[k*LIMIT_BITS +: LIMIT_BITS];
		hi = lim_high[k*LIMIT_BITS +: LIMIT_BITS];
		if (hi > lo)
			return SAMPLE_BITS'(lo + $urandom_range(0, hi - lo - 1));
		return SAMPLE_BITS'($urandom_range(0, int'(FULL_SCALE)));
	endfunction

	// key-press-like runs, with released stretches and some noise
	task automatic add_runs(input int n);
		int left;
		int pick;
		int len;
		int k;
		left = n;
		k    = 0;
		while (left > 0) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				k   = $urandom_range(0, KEY_COUNT - 1);
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
			end else if (pick < 85) begin
				len = $urandom_range(1, 6);
			end else begin
				len = $urandom_range(1, 3);
			end
			if (len > left)
				len = left;
			repeat (len) begin
				if (pick < 70)
					sample_queue.push_back(window_sample(k));
				else if (pick < 85)
					sample_queue.push_back(SAMPLE_BITS'($urandom_range(int'(NOKEY_MAX) + 1,
						int'(FULL_SCALE))));
				else
					sample_queue.push_back(SAMPLE_BITS'($urandom_range(0, int'(FULL_SCALE))));
			end
			left -= len;
		end
	endtask

	task automatic program_phase(input int p);
		logic [LIMITS_BITS-1:0] lo_pack;
		logic [LIMITS_BITS-1:0] hi_pack;
		int                     lo;
		int                     hi;
		case (p)
			0: program_all(LADDER_LOW, LADDER_HIGH, 2, 3, 1, 0, 1, 2);
			1: program_all(LADDER_LOW, LADDER_HIGH, 255, 255, 255, 0, 0, 0);
			2: program_all('0, '1, 0, 0, 0, hold_pick(), 3, hold_pick());
			default: begin
				for (int k = 0; k < KEY_COUNT; k++) begin
					lo = $urandom_range(0, 3900);
					hi = lo + $urandom_range(1, 600);
					if (hi > int'(FULL_SCALE))
						hi = int'(FULL_SCALE);
					lo_pack[k*LIMIT_BITS +: LIMIT_BITS] = LIMIT_BITS'(lo);
					hi_pack[k*LIMIT_BITS +: LIMIT_BITS] = LIMIT_BITS'(hi);
				end
				program_all(lo_pack, hi_pack, $urandom_range(0, 6), $urandom_range(0, 4),
					$urandom_range(0, 4), hold_pick(), hold_pick(), hold_pick());
			end
		endcase
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset defaults: every window empty, nothing can be recognized
		sample_queue = '{12'd0, 12'd4095, 12'd2048, 12'd3968, 12'd3969, 12'd1};
		settle();

		// directed: press, slow and fast repeat, all held events, overlap,
		// release next to press, no-key boundary, window edges
		program_all(LADDER_LOW, LADDER_HIGH, 1, 1, 0, 0, 1, 1);
		sample_queue = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd499, 12'd0, 12'd0, 12'd0,
			12'd450, 12'd450, 12'd450, 12'd450, 12'd3968, 12'd3969, 12'd4095,
			12'd1799, 12'd1000, 12'd2600, 12'd2599, 12'd4000, 12'd4000, 12'd4000,
			12'd4000};
		settle();

		// long hold at the fast rate, held event mid-run, disabled holds,
		// masked register write
		program_all(LADDER_LOW, LADDER_HIGH, 0, 255, 0, 20, 256, '1);
		repeat (36) sample_queue.push_back(window_sample(2));
		repeat (4) sample_queue.push_back(FULL_SCALE);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			program_phase(p);
			add_runs(PHASE_SAMPLES);
			settle();
		end

		if (mismatch_count == 0 && pending_events.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### resistor_ladder_keypad_events.f
+incdir+sv
sv/rlke_pkg.sv
sv/rlke_front.sv
sv/rlke_fifo.sv
sv/rlke_back.sv
sv/resistor_ladder_keypad_events.sv
tb/tb_resistor_ladder_keypad_events.sv
